/* rtl/necirtx_pkg.sv */
// package for the nec ir frame transmitter: types, register map and reset values
`default_nettype none

package necirtx_pkg;

  // parameter defaults
  localparam int unsigned CODE_BITS_DEFAULT   = 32;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 13;

  // fixed field widths
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned CODE_W      = 32;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned PHASE_W     = 4;
  localparam int unsigned BIT_IDX_W   = 6;

  // register reset values
  localparam logic [CODE_W-1:0] CODE_WORD_RST    = 32'h02FD48B7;
  localparam logic [LEN_W-1:0]  LEAD_MARK_RST    = 13'd341;
  localparam logic [LEN_W-1:0]  LEAD_SPACE_RST   = 13'd171;
  localparam logic [LEN_W-1:0]  BIT_MARK_RST     = 13'd22;
  localparam logic [LEN_W-1:0]  ZERO_SPACE_RST   = 13'd21;
  localparam logic [LEN_W-1:0]  ONE_SPACE_RST    = 13'd64;
  localparam logic [LEN_W-1:0]  REPEAT_SPACE_RST = 13'd86;
  localparam logic [LEN_W-1:0]  FRAME_TICKS_RST  = 13'd4096;

  typedef enum logic [2:0] {
    REG_CODE_WORD    = 3'd0,
    REG_LEAD_MARK    = 3'd1,
    REG_LEAD_SPACE   = 3'd2,
    REG_BIT_MARK     = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_SPACE    = 3'd5,
    REG_REPEAT_SPACE = 3'd6,
    REG_FRAME_TICKS  = 3'd7
  } reg_idx_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE       = 4'd0,
    PH_LEAD_MARK  = 4'd1,
    PH_LEAD_SPACE = 4'd2,
    PH_BIT_MARK   = 4'd3,
    PH_BIT_SPACE  = 4'd4,
    PH_STOP_MARK  = 4'd5,
    PH_STOP_SPACE = 4'd6,
    PH_REP_MARK   = 4'd7,
    PH_REP_SPACE  = 4'd8
  } phase_e;

  typedef struct packed {
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  lead_mark;
    logic [LEN_W-1:0]  lead_space;
    logic [LEN_W-1:0]  bit_mark;
    logic [LEN_W-1:0]  zero_space;
    logic [LEN_W-1:0]  one_space;
    logic [LEN_W-1:0]  repeat_space;
    logic [LEN_W-1:0]  frame_ticks;
  } cfg_t;

  typedef struct packed {
    logic               mark_on;
    logic [PHASE_W-1:0] phase_code;
    logic               frame_done;
  } res_t;

endpackage

`default_nettype wire

/* rtl/necirtx_regs.sv */
// apb register file holding the code word and the phase lengths
`default_nettype none

module necirtx_regs import necirtx_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_CODE_WORD:    cfg_d.code_word    = pwdata[CODE_W-1:0];
        REG_LEAD_MARK:    cfg_d.lead_mark    = pwdata[LEN_W-1:0];
        REG_LEAD_SPACE:   cfg_d.lead_space   = pwdata[LEN_W-1:0];
        REG_BIT_MARK:     cfg_d.bit_mark     = pwdata[LEN_W-1:0];
        REG_ZERO_SPACE:   cfg_d.zero_space   = pwdata[LEN_W-1:0];
        REG_ONE_SPACE:    cfg_d.one_space    = pwdata[LEN_W-1:0];
        REG_REPEAT_SPACE: cfg_d.repeat_space = pwdata[LEN_W-1:0];
        REG_FRAME_TICKS:  cfg_d.frame_ticks  = pwdata[LEN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CODE_WORD:    prdata = APB_DATA_W'(cfg_q.code_word);
      REG_LEAD_MARK:    prdata = APB_DATA_W'(cfg_q.lead_mark);
      REG_LEAD_SPACE:   prdata = APB_DATA_W'(cfg_q.lead_space);
      REG_BIT_MARK:     prdata = APB_DATA_W'(cfg_q.bit_mark);
      REG_ZERO_SPACE:   prdata = APB_DATA_W'(cfg_q.zero_space);
      REG_ONE_SPACE:    prdata = APB_DATA_W'(cfg_q.one_space);
      REG_REPEAT_SPACE: prdata = APB_DATA_W'(cfg_q.repeat_space);
      REG_FRAME_TICKS:  prdata = APB_DATA_W'(cfg_q.frame_ticks);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_word    <= CODE_WORD_RST;
      cfg_q.lead_mark    <= LEAD_MARK_RST;
      cfg_q.lead_space   <= LEAD_SPACE_RST;
      cfg_q.bit_mark     <= BIT_MARK_RST;
      cfg_q.zero_space   <= ZERO_SPACE_RST;
      cfg_q.one_space    <= ONE_SPACE_RST;
      cfg_q.repeat_space <= REPEAT_SPACE_RST;
      cfg_q.frame_ticks  <= FRAME_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/necirtx_fsm.sv */
// phase sequencer: tick counting, bit walk, frame padding and repeat decision
`default_nettype none

module necirtx_fsm import necirtx_pkg::*; #(
  parameter int unsigned CODE_BITS   = CODE_BITS_DEFAULT,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic step_i,
  input  wire logic tick_i,
  input  wire logic button_i,
  output res_t      res_o
);

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned CalcW  = 17;
  localparam int unsigned BpW    = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam logic [CW-1:0]  CountMax = '1;
  localparam logic [BpW-1:0] BitTop   = BpW'(CODE_BITS - 1);

  phase_e         phase_q, phase_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [BpW-1:0] bitpos_q, bitpos_d;
  logic [CW-1:0]  elapsed_q, elapsed_d;
  logic [CW-1:0]  pad_q, pad_d;

  logic [BIT_IDX_W-1:0] bp_ext;
  logic                 cur_bit;
  logic [CW-1:0]        len;
  logic [CW-1:0]        cnt_inc;
  logic [CW:0]          acc_sum;
  logic [CW-1:0]        acc;
  logic [CW-1:0]        ft;
  logic [CW-1:0]        pad_calc;
  logic                 done;

  // length registers count as at least 1 and at most the counter range
  function automatic logic [CW-1:0] clamp_len(input logic [CalcW-1:0] v);
    logic [CalcW-1:0] top;
    top = CalcW'(CountMax);
    if (v == '0) begin
      return CW'(1);
    end else if (v > top) begin
      return CountMax;
    end else begin
      return v[CW-1:0];
    end
  endfunction

  always_comb begin
    bp_ext  = BIT_IDX_W'(bitpos_q);
    // positions past the code word read as zero
    cur_bit = bp_ext[5] ? 1'b0 : cfg_i.code_word[bp_ext[4:0]];

    case (phase_q)
      PH_LEAD_MARK:  len = clamp_len(CalcW'(cfg_i.lead_mark));
      PH_LEAD_SPACE: len = clamp_len(CalcW'(cfg_i.lead_space));
      PH_BIT_MARK:   len = clamp_len(CalcW'(cfg_i.bit_mark));
      PH_BIT_SPACE:  len = clamp_len(cur_bit ? CalcW'(cfg_i.one_space)
                                             : CalcW'(cfg_i.zero_space));
      PH_STOP_MARK:  len = clamp_len(CalcW'(cfg_i.bit_mark));
      PH_STOP_SPACE: len = clamp_len(CalcW'(pad_q));
      PH_REP_MARK:   len = clamp_len(CalcW'(cfg_i.lead_mark));
      PH_REP_SPACE:  len = clamp_len(CalcW'(cfg_i.repeat_space));
      default:       len = CW'(1);
    endcase

    cnt_inc  = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
    acc_sum  = {1'b0, elapsed_q} + {1'b0, cnt_inc};
    acc      = acc_sum[CW] ? CountMax : acc_sum[CW-1:0];
    ft       = clamp_len(CalcW'(cfg_i.frame_ticks));
    // padded stop space, one tick when the frame already overran
    pad_calc = (ft > acc) ? ft - acc : CW'(1);
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    bitpos_d  = bitpos_q;
    elapsed_d = elapsed_q;
    pad_d     = pad_q;
    done      = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (button_i) begin
        phase_d   = PH_LEAD_MARK;
        cnt_d     = '0;
        elapsed_d = '0;
        bitpos_d  = BitTop;
      end
    end else if (tick_i) begin
      if (cnt_inc < len) begin
        cnt_d = cnt_inc;
      end else begin
        cnt_d = '0;
        case (phase_q)
          PH_LEAD_MARK: begin
            elapsed_d = acc;
            phase_d   = PH_LEAD_SPACE;
          end
          PH_LEAD_SPACE: begin
            elapsed_d = acc;
            phase_d   = PH_BIT_MARK;
          end
          PH_BIT_MARK: begin
            elapsed_d = acc;
            phase_d   = PH_BIT_SPACE;
          end
          PH_BIT_SPACE: begin
            elapsed_d = acc;
            if (bitpos_q == '0) begin
              phase_d = PH_STOP_MARK;
            end else begin
              bitpos_d = bitpos_q - 1'b1;
              phase_d  = PH_BIT_MARK;
            end
          end
          PH_STOP_MARK: begin
            pad_d     = pad_calc;
            elapsed_d = '0;
            phase_d   = PH_STOP_SPACE;
          end
          PH_STOP_SPACE: begin
            done      = 1'b1;
            elapsed_d = '0;
            phase_d   = button_i ? PH_REP_MARK : PH_IDLE;
          end
          PH_REP_MARK: begin
            elapsed_d = acc;
            phase_d   = PH_REP_SPACE;
          end
          PH_REP_SPACE: begin
            elapsed_d = acc;
            phase_d   = PH_STOP_MARK;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end

    res_o.mark_on    = phase_d inside {PH_LEAD_MARK, PH_BIT_MARK, PH_STOP_MARK, PH_REP_MARK};
    res_o.phase_code = phase_d;
    res_o.frame_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      bitpos_q  <= BitTop;
      elapsed_q <= '0;
      pad_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      bitpos_q  <= bitpos_d;
      elapsed_q <= elapsed_d;
      pad_q     <= pad_d;
    end
  end

  a_hold_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(cnt_q))
    else $error("sequencer state moved without a word");

  a_idle_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_IDLE && !button_i |=> phase_q == PH_IDLE)
    else $error("left idle without a press");

  a_no_tick_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !tick_i && phase_q != PH_IDLE |=> $stable(phase_q) && $stable(cnt_q))
    else $error("phase advanced without a tick");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> elapsed_q == '0)
    else $error("frame time left over in idle");

  a_done_from_stop_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.frame_done |-> phase_q == PH_STOP_SPACE)
    else $error("frame done outside the padded space");

endmodule

`default_nettype wire

/* rtl/nec_ir_frame_transmitter.sv */
// top level of the nec ir frame transmitter: input stage, register file, sequencer, result stage
//
//  channel  | dir | handshake                | word
//  s_axis   | in  | s_axis_tvalid/tready     | tdata[0] tick_elapsed, [1] button_pressed
//  m_axis   | out | m_axis_tvalid/tready     | tdata[0] mark_on, [4:1] phase_code; tlast
//  apb      | in  | psel/penable, pready = 1 | registers 0..7 at 4*i
//
//  one word per cycle sustained while m_axis is ready; a result is offered once its word
//  has passed the input register and then the sequencer logic into the result register
//  rate is set by the phase update feeding the state registers
//  reset (rst_ni low, async) clears both stages to empty and the sequencer to idle
//  a stalled m_axis holds the result; the input stage still takes one more word
`default_nettype none

module nec_ir_frame_transmitter import necirtx_pkg::*; #(
  parameter int unsigned CODE_BITS   = CODE_BITS_DEFAULT,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [0] tick_elapsed, [1] button_pressed, [7:2] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] mark_on, [4:1] phase_code, [7:5] zero
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // frame_done
  output logic                        m_axis_tlast,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready
);

  cfg_t cfg;
  res_t res;

  logic in_valid_q, in_valid_d;
  logic in_tick_q, in_btn_q;
  logic out_valid_q, out_valid_d;
  res_t out_res_q;
  logic advance;
  logic in_take;

  necirtx_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  necirtx_fsm #(
    .CODE_BITS   (CODE_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .tick_i   (in_tick_q),
    .button_i (in_btn_q),
    .res_o    (res)
  );

  // the input word moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_tick_q <= s_axis_tdata[0];
      in_btn_q  <= s_axis_tdata[1];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_res_q.phase_code, out_res_q.mark_on});
  assign m_axis_tlast  = out_res_q.frame_done;

endmodule

`default_nettype wire
